// ----- src/bpr_pkg.sv -----
// Package for the button poll machine: state codes, event codes, register indexes, config type.
package bpr_pkg;

  localparam int unsigned CFG_WIDTH   = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned STATE_W     = 3;
  localparam int unsigned EVENT_W     = 3;
  localparam int unsigned DT_W        = 8;

  // button states
  localparam logic [STATE_W-1:0] ST_IDLE     = 3'd0;
  localparam logic [STATE_W-1:0] ST_DEBOUNCE = 3'd1;
  localparam logic [STATE_W-1:0] ST_PRESSED  = 3'd2;
  localparam logic [STATE_W-1:0] ST_REPEAT   = 3'd3;
  localparam logic [STATE_W-1:0] ST_RELEASE  = 3'd4;

  // event codes
  localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
  localparam logic [EVENT_W-1:0] EV_PRESS   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_LONG    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_REPEAT  = 3'd3;
  localparam logic [EVENT_W-1:0] EV_RELEASE = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IDLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE  = 3'd4;

  // register reset values
  localparam logic [CFG_WIDTH-1:0] IDLE_RST     = 16'd10;
  localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RST = 16'd20;
  localparam logic [CFG_WIDTH-1:0] LONG_RST     = 16'd1000;
  localparam logic [CFG_WIDTH-1:0] REPEAT_RST   = 16'd200;
  localparam logic [CFG_WIDTH-1:0] RELEASE_RST  = 16'd20;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] idle_time;
    logic [CFG_WIDTH-1:0] debounce_time;
    logic [CFG_WIDTH-1:0] long_press_time;
    logic [CFG_WIDTH-1:0] repeat_time;
    logic [CFG_WIDTH-1:0] release_time;
  } bpr_cfg_t;

endpackage

// ----- src/bpr_if.sv -----
// Handshake channels for button polls and poll results.
interface bpr_in_if;
  logic       valid;
  logic       ready;
  logic       pin_level;
  logic [7:0] ticks_passed;

  modport source (output valid, output pin_level, output ticks_passed, input ready);
  modport sink   (input valid, input pin_level, input ticks_passed, output ready);
endinterface

interface bpr_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;
  logic [2:0] button_state;

  modport source (output valid, output event_code, output button_state, input ready);
  modport sink   (input valid, input event_code, input button_state, output ready);
endinterface

// ----- src/button_press_repeat_fsm.sv -----
// Top level of the button poll machine: debounce, press, long press, repeat, release.
//
//  channel   dir  signals                       transaction
//  in_ch     in   pin_level, ticks_passed       one button poll
//  out_ch    out  event_code, button_state      one result per poll
//  cfg_*     in   cfg_wr_en, cfg_index, cfg_data one register write
//
// Each poll is handled combinationally; its result lands in an output
// register in the cycle after acceptance. Polls can be accepted every
// cycle while in_ch.ready is high; it drops only while a result is held
// and out_ch.ready is low. Reset (rst, synchronous) returns the machine
// to idle, clears the tick counter and timeout, reloads register defaults.
module button_press_repeat_fsm
  import bpr_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 16
)
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_WIDTH-1:0] cfg_data,
  bpr_in_if.sink               in_ch,
  bpr_out_if.source            out_ch
);

  bpr_cfg_t cfg;

  bpr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_wr_en),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bpr_core #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule

// ----- src/bpr_cfg.sv -----
// Configuration register file for the five timing registers.
module bpr_cfg
  import bpr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [CFG_WIDTH-1:0] wr_data,
  output bpr_cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_time       <= IDLE_RST;
      cfg.debounce_time   <= DEBOUNCE_RST;
      cfg.long_press_time <= LONG_RST;
      cfg.repeat_time     <= REPEAT_RST;
      cfg.release_time    <= RELEASE_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IDLE:     cfg.idle_time       <= wr_data;
        REG_DEBOUNCE: cfg.debounce_time   <= wr_data;
        REG_LONG:     cfg.long_press_time <= wr_data;
        REG_REPEAT:   cfg.repeat_time     <= wr_data;
        REG_RELEASE:  cfg.release_time    <= wr_data;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

endmodule

// ----- src/bpr_core.sv -----
// Poll state machine, elapsed-tick counter and result register.
module bpr_core
  import bpr_pkg::*;
#(
  parameter int unsigned TICK_WIDTH = 16
)
(
  input  logic     clk,
  input  logic     rst,
  input  bpr_cfg_t cfg,
  bpr_in_if.sink   in_ch,
  bpr_out_if.source out_ch
);

  localparam int unsigned CW = (TICK_WIDTH > CFG_WIDTH) ? TICK_WIDTH : CFG_WIDTH;

  logic [STATE_W-1:0]    fsm_state, fsm_state_next;
  logic [TICK_WIDTH-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [CFG_WIDTH-1:0]  active_timeout, active_timeout_next;
  logic [EVENT_W-1:0]    ev;

  logic                  out_valid;
  logic [EVENT_W-1:0]    event_code;
  logic [STATE_W-1:0]    button_state;

  logic                  accept;
  logic                  low;
  logic [TICK_WIDTH:0]   sum;
  logic [TICK_WIDTH-1:0] elapsed_sat;
  logic [CW-1:0]         elapsed_cmp;
  logic                  expired;
  logic                  idle_due;

  // a new poll enters whenever the result slot is free or draining
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign low         = !in_ch.pin_level;

  assign sum         = {1'b0, elapsed_ticks} + (TICK_WIDTH+1)'(in_ch.ticks_passed);
  assign elapsed_sat = sum[TICK_WIDTH] ? {TICK_WIDTH{1'b1}} : sum[TICK_WIDTH-1:0];
  assign elapsed_cmp = CW'(elapsed_sat);
  assign expired     = elapsed_cmp > CW'(active_timeout);
  assign idle_due    = elapsed_cmp > CW'(cfg.idle_time);

  always_comb begin
    fsm_state_next      = fsm_state;
    elapsed_ticks_next  = elapsed_sat;
    active_timeout_next = active_timeout;
    ev                  = EV_NONE;
    unique case (fsm_state)
      ST_IDLE: begin
        if (idle_due) begin
          if (low) begin
            fsm_state_next      = ST_DEBOUNCE;
            active_timeout_next = cfg.debounce_time;
          end else begin
            active_timeout_next = cfg.idle_time;
          end
          elapsed_ticks_next = '0;
        end
      end
      ST_DEBOUNCE: begin
        if (!low) begin
          fsm_state_next      = ST_IDLE;
          active_timeout_next = cfg.idle_time;
        end else if (expired) begin
          ev                  = EV_PRESS;
          fsm_state_next      = ST_PRESSED;
          active_timeout_next = cfg.long_press_time;
          elapsed_ticks_next  = '0;
        end
      end
      ST_PRESSED: begin
        if (!low) begin
          fsm_state_next      = ST_RELEASE;
          active_timeout_next = cfg.release_time;
        end else if (expired) begin
          ev                  = EV_LONG;
          fsm_state_next      = ST_REPEAT;
          active_timeout_next = cfg.repeat_time;
          elapsed_ticks_next  = '0;
        end
      end
      ST_REPEAT: begin
        if (!low) begin
          fsm_state_next      = ST_RELEASE;
          active_timeout_next = cfg.release_time;
        end else if (expired) begin
          ev                 = EV_REPEAT;
          elapsed_ticks_next = '0;
        end
      end
      ST_RELEASE: begin
        if (low) begin
          fsm_state_next      = ST_IDLE;
          active_timeout_next = cfg.idle_time;
        end else if (expired) begin
          ev                  = EV_RELEASE;
          fsm_state_next      = ST_IDLE;
          active_timeout_next = cfg.idle_time;
          elapsed_ticks_next  = '0;
        end
      end
      default: ;  // unused codes: counter still accumulates, no event
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state      <= ST_IDLE;
      elapsed_ticks  <= '0;
      active_timeout <= '0;
    end else if (accept) begin
      fsm_state      <= fsm_state_next;
      elapsed_ticks  <= elapsed_ticks_next;
      active_timeout <= active_timeout_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      event_code   <= ev;
      button_state <= fsm_state_next;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.event_code   = event_code;
  assign out_ch.button_state = button_state;

endmodule
